@@ hdl/indexed_min_heap_assert.svh @@
// Assertion macros for the indexed min-heap.
`ifndef INDEXED_MIN_HEAP_ASSERT_SVH
`define INDEXED_MIN_HEAP_ASSERT_SVH
// Property that holds after reset is released.
`define IMH_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Property checked also during reset.
`define IMH_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);
`endif

@@ hdl/imh_pkg.sv @@
// Package with types and constants of the indexed min-heap.
`timescale 1ns / 1ps
`default_nettype none
package imh_pkg;
   localparam int CAPACITY   = 256;
   localparam int KEY_BITS   = 32;
   localparam int SLOT_BITS  = $clog2(CAPACITY);
   localparam int COUNT_BITS = SLOT_BITS + 1;

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_POPMIN = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_DEAD  = 2'd2;
   localparam logic [1:0] ST_EMPTY = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] key;
      logic [7:0]  handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  out_handle;
      logic [31:0] out_key;
      logic [8:0]  count;
   } rsp_type;

   // Heap slot entry: key and handle.
   typedef struct packed {
      logic [KEY_BITS-1:0]  key;
      logic [SLOT_BITS-1:0] hnd;
   } slot_type;
endpackage
`default_nettype wire

@@ hdl/imh_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module imh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

@@ hdl/imh_ctrl.sv @@
// Sequencer for heap operations around one shared key comparator.
`timescale 1ns / 1ps
`default_nettype none
module imh_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire imh_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output imh_pkg::rsp_type      rsp_data,
   output logic                  busy
);
   import imh_pkg::*;

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00000000000001,
      S_SCAN  = 14'b00000000000010,
      S_HMAP  = 14'b00000000000100,
      S_RDPOS = 14'b00000000001000,
      S_RDLST = 14'b00000000010000,
      S_RDPAR = 14'b00000000100000,
      S_UPCMP = 14'b00000001000000,
      S_UPRD  = 14'b00000010000000,
      S_DNRD1 = 14'b00000100000000,
      S_DNC1  = 14'b00001000000000,
      S_DNC2  = 14'b00010000000000,
      S_DNCMP = 14'b00100000000000,
      S_PLACE = 14'b01000000000000,
      S_DONE  = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SLOT_BITS-1:0]  aptr_ff, aptr_in;
   logic [SLOT_BITS-1:0]  pos_ff, pos_in;     // current hole
   logic [SLOT_BITS-1:0]  oth_ff, oth_in;     // parent or chosen child
   slot_type              mv_ff, mv_in;       // entry being sifted
   slot_type              c1_ff, c1_in;
   rsp_type               rsp_ff, rsp_in;
   logic                  rv_ff, rv_in;
   logic [CAPACITY-1:0]   live_ff, live_in;

   // Slot RAM and handle map RAM.
   logic                  s_we, m_we;
   logic [SLOT_BITS-1:0]  s_addr, m_addr;
   slot_type              s_wd, s_rd;
   logic [SLOT_BITS-1:0]  m_wd, m_rd;

   imh_ram #(.WIDTH($bits(slot_type)), .DEPTH(CAPACITY)) u_slots (
      .clock(clock), .wr_en(s_we), .addr(s_addr), .wr_data(s_wd), .rd_data(s_rd));
   imh_ram #(.WIDTH(SLOT_BITS), .DEPTH(CAPACITY)) u_hmap (
      .clock(clock), .wr_en(m_we), .addr(m_addr), .wr_data(m_wd), .rd_data(m_rd));

   // The one shared comparator: a < b.
   logic [KEY_BITS-1:0] cmp_a, cmp_b;
   logic                cmp_lt;
   assign cmp_lt = cmp_a < cmp_b;

   logic [SLOT_BITS-1:0] last_idx, par_idx, ins_par;
   logic [COUNT_BITS:0]  ch1, ch2;
   assign last_idx = SLOT_BITS'(count_ff - COUNT_BITS'(1));
   assign par_idx  = (pos_ff - SLOT_BITS'(1)) >> 1;
   assign ins_par  = (count_ff[SLOT_BITS-1:0] - SLOT_BITS'(1)) >> 1;
   assign ch1      = {1'b0, pos_ff, 1'b1};
   assign ch2      = ch1 + (COUNT_BITS+1)'(1);

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;
   assign busy      = state_ff != S_IDLE;

   always_comb begin
      state_in = state_ff; count_in = count_ff; aptr_in = aptr_ff;
      pos_in = pos_ff; oth_in = oth_ff; mv_in = mv_ff;
      c1_in = c1_ff; rsp_in = rsp_ff; live_in = live_ff;
      rv_in = rv_ff && !rsp_ready;
      s_we = 1'b0; m_we = 1'b0; s_addr = pos_ff; m_addr = mv_ff.hnd;
      s_wd = mv_ff; m_wd = pos_ff;
      cmp_a = mv_ff.key; cmp_b = s_rd.key;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               rsp_in = '0;
               rsp_in.count = count_ff;
               mv_in.key = KEY_BITS'(req_data.key);
               mv_in.hnd = aptr_ff;
               unique case (req_data.kind)
                  KIND_INSERT: begin
                     if (count_ff >= COUNT_BITS'(CAPACITY)) begin
                        rsp_in.status = ST_FULL; state_in = S_DONE;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  KIND_REMOVE: begin
                     rsp_in.out_handle = req_data.handle;
                     if (!live_ff[req_data.handle[SLOT_BITS-1:0]]) begin
                        rsp_in.status = ST_DEAD; state_in = S_DONE;
                     end else begin
                        m_addr = req_data.handle[SLOT_BITS-1:0]; state_in = S_HMAP;
                     end
                  end
                  KIND_POPMIN: begin
                     if (count_ff == '0) begin
                        rsp_in.status = ST_EMPTY; state_in = S_DONE;
                     end else begin
                        pos_in = '0; s_addr = '0; state_in = S_RDPOS;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         // Next-fit scan, one handle per cycle.
         S_SCAN: begin
            if (!live_ff[mv_ff.hnd]) begin
               rsp_in.out_handle = 8'(mv_ff.hnd);
               aptr_in = mv_ff.hnd + SLOT_BITS'(1);
               live_in[mv_ff.hnd] = 1'b1;
               count_in = count_ff + COUNT_BITS'(1);
               rsp_in.count = count_ff + COUNT_BITS'(1);
               pos_in = count_ff[SLOT_BITS-1:0];
               if (count_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  s_addr = ins_par; oth_in = ins_par; state_in = S_UPCMP;
               end
            end else begin
               mv_in.hnd = mv_ff.hnd + SLOT_BITS'(1);
            end
         end
         S_HMAP: begin
            pos_in = m_rd; s_addr = m_rd; state_in = S_RDPOS;
         end
         // Removed entry read; fetch last slot.
         S_RDPOS: begin
            rsp_in.out_handle = 8'(s_rd.hnd);
            rsp_in.out_key = 32'(s_rd.key);
            live_in[s_rd.hnd] = 1'b0;
            count_in = count_ff - COUNT_BITS'(1);
            rsp_in.count = count_ff - COUNT_BITS'(1);
            s_addr = last_idx;
            if (COUNT_BITS'(pos_ff) == count_ff - COUNT_BITS'(1)) state_in = S_DONE;
            else state_in = S_RDLST;
         end
         // At the root the moved entry can only go down.
         S_RDLST: begin
            mv_in = s_rd;
            if (pos_ff == '0) begin
               state_in = S_DNRD1;
            end else begin
               oth_in = par_idx; s_addr = par_idx; state_in = S_RDPAR;
            end
         end
         // s_rd holds the parent at oth; the first compare after a removal
         // picks the direction, sifting down unless strictly smaller.
         S_RDPAR, S_UPCMP: begin
            if (cmp_lt) begin
               s_addr = pos_ff; s_we = 1'b1; s_wd = s_rd;
               m_addr = s_rd.hnd; m_we = 1'b1; m_wd = pos_ff;
               pos_in = oth_ff;
               if (oth_ff == '0) begin
                  state_in = S_PLACE;
               end else begin
                  oth_in = (oth_ff - SLOT_BITS'(1)) >> 1;
                  state_in = S_UPRD;
               end
            end else if (state_ff == S_RDPAR) begin
               state_in = S_DNRD1;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_UPRD: begin
            s_addr = oth_ff; state_in = S_UPCMP;
         end
         S_DNRD1: begin
            if (ch1 >= (COUNT_BITS+1)'(count_ff)) begin
               state_in = S_PLACE;
            end else begin
               s_addr = ch1[SLOT_BITS-1:0]; state_in = S_DNC1;
            end
         end
         S_DNC1: begin
            c1_in = s_rd; oth_in = ch1[SLOT_BITS-1:0];
            if (ch2 < (COUNT_BITS+1)'(count_ff)) begin
               s_addr = ch2[SLOT_BITS-1:0]; state_in = S_DNC2;
            end else begin
               state_in = S_DNCMP;
            end
         end
         // Pick the smaller child; on a tie the left one stays.
         S_DNC2: begin
            cmp_a = s_rd.key; cmp_b = c1_ff.key;
            if (cmp_lt) begin
               c1_in = s_rd; oth_in = ch2[SLOT_BITS-1:0];
            end
            state_in = S_DNCMP;
         end
         S_DNCMP: begin
            cmp_a = c1_ff.key; cmp_b = mv_ff.key;
            if (cmp_lt) begin
               s_addr = pos_ff; s_we = 1'b1; s_wd = c1_ff;
               m_addr = c1_ff.hnd; m_we = 1'b1; m_wd = pos_ff;
               pos_in = oth_ff; state_in = S_DNRD1;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            s_addr = pos_ff; s_we = 1'b1; s_wd = mv_ff;
            m_addr = mv_ff.hnd; m_we = 1'b1; m_wd = pos_ff;
            rv_in = 1'b1; state_in = S_IDLE;
         end
         S_DONE: begin
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; aptr_ff <= '0; rv_ff <= 1'b0;
         live_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in; aptr_ff <= aptr_in; rv_ff <= rv_in; live_ff <= live_in;
      end
      pos_ff <= pos_in; oth_ff <= oth_in; mv_ff <= mv_in;
      c1_ff <= c1_in; rsp_ff <= rsp_in;
   end
endmodule
`default_nettype wire

@@ hdl/indexed_min_heap.sv @@
// Indexed binary min-heap: insert, remove by handle, remove minimum.
// A rejected or unused request goes straight to the response; an insert scans for a free
// handle, skipping live ones, then sifts up with one key compare per level (at most 8),
// and a removal sifts the last entry up or down from the freed slot.
// One request at a time; the next is not accepted until the response has been taken.
// Reset is synchronous, active high; it clears live flags, count and pointer.
`timescale 1ns / 1ps
`default_nettype none
`include "indexed_min_heap_assert.svh"
module indexed_min_heap (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire imh_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output imh_pkg::rsp_type      rsp_data
);
   import imh_pkg::*;
   logic busy;

   imh_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_data(rsp_data), .busy(busy));

   `IMH_ASSERT(a_no_ready_busy, busy |-> !req_ready, "ready while busy")
   `IMH_ASSERT(a_count_range, rsp_valid |-> rsp_data.count <= 9'(CAPACITY), "count overflow")
   `IMH_ASSERT(a_no_ready_rsp, rsp_valid |-> !req_ready, "ready with pending response")
   `IMH_ASSERT_ALWAYS(a_reset, reset |=> !rsp_valid, "response after reset")
endmodule
`default_nettype wire
